@@ sv/sha_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 compression engine.
// No dependencies; used by sha_front, sha_queue, sha_back and the top level.
package sha_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 64;
    localparam int HASH_WORDS  = 8;
    localparam int QUEUE_DEPTH = 4;

    // Classified message word as handed from the front to the back
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              start;   // reload the initial hash before this word
        logic              last;    // sixteenth word of a block
        logic              emit;    // emit the digest after this block
    } t_item;

    localparam logic [WORD_W-1:0] INITIAL_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

endpackage

@@ sv/sha_front.sv @@
// Front end: takes message word transfers, tracks the position in the block
// and tags each word for the back end. Depends on sha_pkg.
module sha_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [sha_pkg::WORD_W-1:0] i_message_word,
    input  logic                       i_start_message,
    input  logic                       i_end_message,
    output logic                       o_push,
    output sha_pkg::t_item             o_item
);

    logic [3:0] r_count;
    logic [3:0] n_count;
    logic [3:0] w_pos;
    logic       w_last;

    // a start flag always opens a new block, dropping any partial one
    assign w_pos   = i_start_message ? 4'd0 : r_count;
    assign w_last  = (w_pos == 4'(sha_pkg::BLOCK_WORDS - 1));
    assign n_count = w_last ? 4'd0 : w_pos + 4'd1;

    assign o_push      = i_accept;
    assign o_item.word  = i_message_word;
    assign o_item.start = i_start_message;
    assign o_item.last  = w_last;
    assign o_item.emit  = i_end_message & w_last;   // early end flags are dropped

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 4'd0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

endmodule

@@ sv/sha_queue.sv @@
// Short queue of tagged message words between front and back end.
// Depends on sha_pkg.
module sha_queue #(
    parameter int DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sha_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output sha_pkg::t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sha_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    ap_no_pop_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("queue popped while empty");

    ap_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != CNT_W'(DEPTH)))
        else $error("queue pushed while full");

endmodule

@@ sv/sha_back.sv @@
// Back end: message schedule window, one SHA-256 round per cycle, hash update
// and registered digest output. Depends on sha_pkg.
module sha_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_item_valid,
    input  sha_pkg::t_item             i_item,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [sha_pkg::WORD_W-1:0] o_digest_word,
    output logic [2:0]                 o_digest_index,
    output logic                       o_digest_last
);

    typedef enum logic [1:0] {S_LOAD, S_ROUND, S_ADD, S_EMIT} t_state;

    t_state                     r_state;
    logic [5:0]                 r_round;
    logic [2:0]                 r_idx;
    logic                       r_emit;
    logic [sha_pkg::WORD_W-1:0] r_w [sha_pkg::BLOCK_WORDS];
    logic [sha_pkg::WORD_W-1:0] r_v [sha_pkg::HASH_WORDS];
    logic [sha_pkg::WORD_W-1:0] r_h [sha_pkg::HASH_WORDS];
    logic                       r_out_valid;
    logic [sha_pkg::WORD_W-1:0] r_out_word;
    logic [2:0]                 r_out_idx;
    logic                       r_out_last;

    logic [sha_pkg::WORD_W-1:0] w_sched;
    logic [sha_pkg::WORD_W-1:0] w_ch;
    logic [sha_pkg::WORD_W-1:0] w_maj;
    logic [sha_pkg::WORD_W-1:0] w_t1;
    logic [sha_pkg::WORD_W-1:0] w_t2;
    logic                       w_out_free;

    assign o_pop      = (r_state == S_LOAD) && i_item_valid;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_sched = r_w[0] + sha_pkg::small_sigma0(r_w[1]) + r_w[9]
                + sha_pkg::small_sigma1(r_w[14]);
        w_ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_t1    = r_v[7] + sha_pkg::big_sigma1(r_v[4]) + w_ch
                + sha_pkg::ROUND_K[r_round] + r_w[0];
        w_t2    = sha_pkg::big_sigma0(r_v[0]) + w_maj;
    end

    // schedule window and working variables: no reset needed
    always_ff @(posedge i_clk) begin
        if (o_pop || r_state == S_ROUND) begin
            for (int i = 0; i < sha_pkg::BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[sha_pkg::BLOCK_WORDS-1] <= o_pop ? i_item.word : w_sched;
        end
        if (o_pop && i_item.last) begin
            for (int i = 0; i < sha_pkg::HASH_WORDS; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (r_state == S_ROUND) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_round     <= '0;
            r_idx       <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < sha_pkg::HASH_WORDS; i++) begin
                r_h[i] <= sha_pkg::INITIAL_HASH[i];
            end
        end else begin
            // in the digest state the output register is refilled below
            if (r_out_valid && !i_out_stall && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (o_pop) begin
                        if (i_item.start) begin
                            for (int i = 0; i < sha_pkg::HASH_WORDS; i++) begin
                                r_h[i] <= sha_pkg::INITIAL_HASH[i];
                            end
                        end
                        if (i_item.last) begin
                            r_emit  <= i_item.emit;
                            r_round <= '0;
                            r_state <= S_ROUND;
                        end
                    end
                end
                S_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'(sha_pkg::ROUNDS - 1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    for (int i = 0; i < sha_pkg::HASH_WORDS; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_idx   <= '0;
                    r_state <= r_emit ? S_EMIT : S_LOAD;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_word  <= r_h[r_idx];
                        r_out_idx   <= r_idx;
                        r_out_last  <= (r_idx == 3'(sha_pkg::HASH_WORDS - 1));
                        r_idx       <= r_idx + 3'd1;
                        if (r_idx == 3'(sha_pkg::HASH_WORDS - 1)) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_digest_word  = r_out_word;
    assign o_digest_index = r_out_idx;
    assign o_digest_last  = r_out_last;

    ap_block_starts_rounds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.last) |=> (r_state == S_ROUND && r_round == 6'd0))
        else $error("sixteenth word did not start the rounds");

    ap_rounds_then_add : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round == 6'(sha_pkg::ROUNDS - 1)) |=> (r_state == S_ADD))
        else $error("round sequence did not end in the hash update");

    ap_emit_only_on_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_emit)
        else $error("digest emitted for a block without an end flag");

endmodule

@@ sv/sha256_compression_engine_core.sv @@
// Top level of the SHA-256 compression engine: front end, queue and back end.
// Depends on sha_pkg, sha_front, sha_queue and sha_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one 32-bit big-endian word
//   of an already padded message per transfer, sixteen words to a block.
//   i_start_message on a word reloads the standard initial hash and makes that
//   word the first of a new block; i_end_message on a sixteenth word asks for
//   the digest. An end flag on any other word is ignored.
//   Output channel (o_out_valid / i_out_stall) carries eight transfers per
//   digest, H0 first, with o_digest_index and o_digest_last on the eighth.
// Operation:
//   The back end takes one word per cycle into its schedule window while
//   loading with queue words present, then runs 64 rounds at one round per
//   cycle on its single round unit and then the hash update. Digest words
//   follow from the output register one per cycle after the update, unless stalled.
//   A four-entry queue lets the front take words while rounds are running.
// Reset:
//   Synchronous, active low. Hash state returns to the initial values, block
//   position to zero, queue and output register empty. No clearing pass.
// Stall:
//   A stalled receiver holds the back end in its digest state; the queue then
//   fills and o_in_stall rises.
module sha256_compression_engine_core #(
    parameter int QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [sha_pkg::WORD_W-1:0] i_message_word,
    input  logic                       i_start_message,
    input  logic                       i_end_message,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [sha_pkg::WORD_W-1:0] o_digest_word,
    output logic [2:0]                 o_digest_index,
    output logic                       o_digest_last
);

    logic           w_full;
    logic           w_accept;
    logic           w_push;
    sha_pkg::t_item w_front_item;
    logic           w_q_valid;
    sha_pkg::t_item w_q_item;
    logic           w_pop;

    // stall comes from the queue fill level only, never from i_in_valid
    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    sha_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_message_word  (i_message_word),
        .i_start_message (i_start_message),
        .i_end_message   (i_end_message),
        .o_push          (w_push),
        .o_item          (w_front_item)
    );

    sha_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_full),
        .o_item  (w_q_item)
    );

    sha_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (w_q_valid),
        .i_item         (w_q_item),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_digest_word  (o_digest_word),
        .o_digest_index (o_digest_index),
        .o_digest_last  (o_digest_last)
    );

endmodule
